### rtl/sbda_pkg.sv
// Shared package for the signed binary to decimal ASCII core.
// Holds the character codes, conversion constants and back-end state type.
// No dependencies.
`default_nettype none

package sbda_pkg;

  localparam int VALUE_BITS_DEFAULT = 32;

  localparam int QUEUE_DEPTH = 2;

  // log10(2) rounded up, as a ratio, for sizing the decimal digit count
  localparam int LOG2_NUM = 30103;
  localparam int LOG2_DEN = 100000;

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  localparam logic [3:0] BCD_ADJUST_MIN = 4'd5;
  localparam logic [3:0] BCD_ADJUST     = 4'd3;

  typedef enum logic [1:0] {
    B_IDLE,
    B_CONVERT,
    B_SKIP,
    B_EMIT
  } back_state_t;

endpackage

`default_nettype wire

### rtl/signed_binary_to_decimal_ascii_core.sv
// Converts a two's complement integer to its decimal ASCII text, one character
// per output transaction, most significant first, with last on the final digit.
// A negative value starts with '-', zero gives '0' and no leading zeros appear.
// Each value is loaded, shifted one bit at a time through the bit-serial
// shift-and-add-3 loop, stripped of leading zero digits one at a time, and then
// sent one character per output transaction. Skipped and sent digits always add up
// to the digit count. A two-entry queue lets new values be taken while
// the previous text drains. Depends on sbda_pkg, sbda_front, sbda_queue and sbda_back.
`default_nettype none

module signed_binary_to_decimal_ascii_core #(
  parameter int VALUE_BITS = sbda_pkg::VALUE_BITS_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [VALUE_BITS-1:0] value,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  output logic [7:0]                 character,
  output logic                       last,
  output logic                       out_valid,
  input  wire logic                  out_stall
);

  logic                push_valid;
  logic                push_stall;
  logic [VALUE_BITS:0] push_entry;
  logic                pop_valid;
  logic                pop_stall;
  logic [VALUE_BITS:0] pop_entry;

  sbda_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .value      (value),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_entry (push_entry)
  );

  sbda_queue #(.VALUE_BITS(VALUE_BITS)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_stall  (pop_stall),
    .pop_entry  (pop_entry)
  );

  sbda_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_stall (pop_stall),
    .pop_entry (pop_entry),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .character (character),
    .last      (last)
  );

endmodule

`default_nettype wire

### rtl/sbda_front.sv
// Front end: accepts input transactions and splits each into sign and magnitude.
// Depends on sbda_pkg; feeds sbda_queue.
`default_nettype none

module sbda_front #(
  parameter int VALUE_BITS = sbda_pkg::VALUE_BITS_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [VALUE_BITS-1:0] value,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  output logic                       push_valid,
  input  wire logic                  push_stall,
  output logic [VALUE_BITS:0]        push_entry
);

  logic                  held_valid;
  logic [VALUE_BITS:0]   entry;
  logic                  negative;
  logic [VALUE_BITS-1:0] magnitude;

  assign negative  = value[VALUE_BITS-1];
  assign magnitude = negative ? (~value + VALUE_BITS'(1)) : value;

  assign in_stall   = held_valid && push_stall;
  assign push_valid = held_valid;
  assign push_entry = entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      entry <= {negative, magnitude};
    end
  end

endmodule

`default_nettype wire

### rtl/sbda_queue.sv
// Short queue of sign and magnitude entries between front and back ends.
// Depends on sbda_pkg for its depth.
`default_nettype none

module sbda_queue #(
  parameter int VALUE_BITS = sbda_pkg::VALUE_BITS_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push_valid,
  output logic                     push_stall,
  input  wire logic [VALUE_BITS:0] push_entry,
  output logic                     pop_valid,
  input  wire logic                pop_stall,
  output logic [VALUE_BITS:0]      pop_entry
);

  localparam int PtrW   = $clog2(sbda_pkg::QUEUE_DEPTH);
  localparam int CountW = $clog2(sbda_pkg::QUEUE_DEPTH + 1);

  logic [VALUE_BITS:0] slots [sbda_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [CountW-1:0]   count;
  logic                push;
  logic                pop;

  assign push_stall = (count == CountW'(sbda_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != CountW'(0));
  assign pop_entry  = slots[rd_ptr];
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && !pop_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(sbda_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(sbda_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CountW'(1);
      end else if (pop && !push) begin
        count <= count - CountW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

`default_nettype wire

### rtl/sbda_back.sv
// Back end: bit-serial shift-and-add-3 conversion, leading zero skip and
// character output register. Depends on sbda_pkg; fed by sbda_queue.
`default_nettype none

module sbda_back #(
  parameter int VALUE_BITS = sbda_pkg::VALUE_BITS_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                pop_valid,
  output logic                     pop_stall,
  input  wire logic [VALUE_BITS:0] pop_entry,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [7:0]               character,
  output logic                     last
);

  localparam int NumDigits   = (VALUE_BITS * sbda_pkg::LOG2_NUM + sbda_pkg::LOG2_DEN - 1)
                               / sbda_pkg::LOG2_DEN;
  localparam int BcdW        = 4 * NumDigits;
  localparam int BitCountW   = $clog2(VALUE_BITS + 1);
  localparam int DigitCountW = $clog2(NumDigits + 1);

  sbda_pkg::back_state_t state, state_next;

  logic [BitCountW-1:0]   bit_count, bit_count_next;
  logic [DigitCountW-1:0] digits_left, digits_left_next;
  logic                   neg_pending, neg_pending_next;
  logic [VALUE_BITS-1:0]  shreg, shreg_next;
  logic [BcdW-1:0]        bcd, bcd_next;
  logic [BcdW-1:0]        bcd_adj;
  logic [3:0]             top_digit;
  logic                   out_free;
  logic                   emit;
  logic [7:0]             emit_char;
  logic                   emit_last;

  assign top_digit = bcd[BcdW-1 -: 4];
  assign out_free  = !out_valid || !out_stall;
  assign pop_stall = (state != sbda_pkg::B_IDLE);

  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= sbda_pkg::BCD_ADJUST_MIN)
                        ? bcd[4*i +: 4] + sbda_pkg::BCD_ADJUST : bcd[4*i +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sbda_pkg::B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_free) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    bit_count   <= bit_count_next;
    digits_left <= digits_left_next;
    neg_pending <= neg_pending_next;
    shreg       <= shreg_next;
    bcd         <= bcd_next;
    if (emit) begin
      character <= emit_char;
      last      <= emit_last;
    end
  end

  always_comb begin
    state_next       = state;
    bit_count_next   = bit_count;
    digits_left_next = digits_left;
    neg_pending_next = neg_pending;
    shreg_next       = shreg;
    bcd_next         = bcd;
    emit             = 1'b0;
    emit_char        = sbda_pkg::CHAR_ZERO;
    emit_last        = 1'b0;
    unique case (state)
      sbda_pkg::B_IDLE: begin
        if (pop_valid) begin
          neg_pending_next = pop_entry[VALUE_BITS];
          shreg_next       = pop_entry[VALUE_BITS-1:0];
          bcd_next         = '0;
          bit_count_next   = BitCountW'(VALUE_BITS);
          state_next       = sbda_pkg::B_CONVERT;
        end
      end
      sbda_pkg::B_CONVERT: begin
        bcd_next       = {bcd_adj[BcdW-2:0], shreg[VALUE_BITS-1]};
        shreg_next     = {shreg[VALUE_BITS-2:0], 1'b0};
        bit_count_next = bit_count - BitCountW'(1);
        if (bit_count == BitCountW'(1)) begin
          digits_left_next = DigitCountW'(NumDigits);
          state_next       = sbda_pkg::B_SKIP;
        end
      end
      sbda_pkg::B_SKIP: begin
        if ((top_digit == 4'd0) && (digits_left != DigitCountW'(1))) begin
          bcd_next         = {bcd[BcdW-5:0], 4'd0};
          digits_left_next = digits_left - DigitCountW'(1);
        end else begin
          state_next = sbda_pkg::B_EMIT;
        end
      end
      sbda_pkg::B_EMIT: begin
        if (out_free) begin
          emit = 1'b1;
          if (neg_pending) begin
            emit_char        = sbda_pkg::CHAR_MINUS;
            neg_pending_next = 1'b0;
          end else begin
            emit_char        = sbda_pkg::CHAR_ZERO + {4'd0, top_digit};
            emit_last        = (digits_left == DigitCountW'(1));
            bcd_next         = {bcd[BcdW-5:0], 4'd0};
            digits_left_next = digits_left - DigitCountW'(1);
            if (digits_left == DigitCountW'(1)) begin
              state_next = sbda_pkg::B_IDLE;
            end
          end
        end
      end
      default: begin
        state_next = sbda_pkg::B_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
